// ===== hw/rtl/eflm_pkg.sv =====
`timescale 1ns / 1ps

package eflm_pkg;

    localparam int DISTANCE_BITS_DEFAULT = 12;

    localparam int CFG_W  = 12;
    localparam int RIM_W  = 8;
    localparam int NCAL_W = 8;
    localparam int LVL_W  = 4;
    localparam int NUM_W  = 16;
    localparam int ADDR_W = 2;

    localparam logic [CFG_W-1:0]  BASE_RESET = 12'd537;
    localparam logic [CFG_W-1:0]  TOL_RESET  = 12'd100;
    localparam logic [RIM_W-1:0]  RIM_RESET  = 8'd25;
    localparam logic [NCAL_W-1:0] NCAL_RESET = 8'd63;

    localparam logic [LVL_W-1:0] LEVEL_MAX = 4'd13;

    localparam logic [ADDR_W-1:0] REG_BASE_HEIGHT = 2'd0;
    localparam logic [ADDR_W-1:0] REG_TOLERANCE   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_RIM_OFFSET  = 2'd2;
    localparam logic [ADDR_W-1:0] REG_CAL_SAMPLES = 2'd3;

    typedef enum logic [1:0] {
        PH_CAL  = 2'd0,
        PH_RAW  = 2'd1,
        PH_FILL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_RESET    = 2'd0,
        EV_PRESENT  = 2'd1,
        EV_PROGRESS = 2'd2,
        EV_FULL     = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        event_t           ev;
        logic [LVL_W-1:0] lvl;
        logic             last;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [CFG_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== hw/rtl/echo_fill_level_monitor.sv =====
`timescale 1ns / 1ps

// echo fill level monitor
// input beats on s_axis: tdata carries the echo time, tuser is the action
// (0 new sample, 1 reset system). results leave on m_axis: tuser is the event
// (reset done, cup present, level progress, cup full), tdata the fill level,
// tlast marks the final result of one input beat. an input may cause no result.
// registers are written on the cfg channel (index, data); write them only while
// the block is idle, the block itself does not enforce it. cfg_ready is always high.
// an input beat is taken only in the idle state. a beat without a level update
// goes from acceptance straight to the emit state; a filling sample that needs
// a level first runs through the 16-step serial divider. the block takes no new
// beat until it has queued every result of the current one. the divider sets
// the worst case rate.
// results wait in a two-entry output queue, so a stalled receiver only holds the
// block once the queue cannot take the results of the current beat.
// reset returns all registers but the level register to their defaults, the
// phase to calibration and empties the output queue.

module echo_fill_level_monitor
#(
    parameter int DISTANCE_BITS = eflm_pkg::DISTANCE_BITS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((DISTANCE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // echo_time
    input  logic                                   s_axis_tuser,  // action
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [7:0]                             m_axis_tdata,  // fill_level
    output logic [1:0]                             m_axis_tuser,  // event_res
    output logic                                   m_axis_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [eflm_pkg::ADDR_W-1:0]            cfg_addr,
    input  logic [eflm_pkg::CFG_W-1:0]             cfg_data
);

    localparam int DB = DISTANCE_BITS;
    localparam int CW = ((DB > eflm_pkg::CFG_W) ? DB : eflm_pkg::CFG_W) + 1;
    localparam int FW = DB + 1;
    localparam int LW = eflm_pkg::LVL_W;
    localparam int NW = eflm_pkg::NUM_W;
    localparam int KW = eflm_pkg::CFG_W;
    localparam logic [CW-1:0] BASE_RST_EXT = CW'(eflm_pkg::BASE_RESET);

    // configuration
    logic [KW-1:0]                   base_reg;
    logic [KW-1:0]                   tol_reg;
    logic [eflm_pkg::RIM_W-1:0]      rim_reg;
    logic [eflm_pkg::NCAL_W-1:0]     ncal_reg;

    // state
    eflm_pkg::state_t                state_reg, state_next;
    eflm_pkg::phase_t                phase_reg, phase_next;
    logic [7:0]                      cnt_reg, cnt_next;
    logic [DB-1:0]                   cup_reg, cup_next;
    logic [FW-1:0]                   ft_reg, ft_next;
    logic [DB-1:0]                   ld_reg, ld_next;
    logic [LW-1:0]                   disp_reg, disp_next;
    logic                            flag_reset_reg, flag_reset_next;
    logic                            flag_pres_reg, flag_pres_next;
    logic                            flag_prog_reg, flag_prog_next;
    logic                            flag_full_reg, flag_full_next;
    logic                            emit_idx_reg, emit_idx_next;
    logic [LW-1:0]                   lvl_reg, lvl_next;

    logic                            in_acc;
    logic [DB-1:0]                   echo;
    logic [CW-1:0]                   echo_ext, ld_ext, tol_ext, ft_ext, base_ext;
    logic [CW-1:0]                   new_ld_ext, base_diff, den_diff;
    logic [DB-1:0]                   new_ld;
    logic                            reject;
    logic                            need_div;
    logic [KW-1:0]                   num_base;
    logic [DB-1:0]                   cal_cup;
    logic [7:0]                      cal_cnt;
    logic [7:0]                      cal_need;
    logic [FW-1:0]                   cal_ft;
    logic [LW-1:0]                   div_lvl;
    logic                            prog_first;

    eflm_pkg::div_req_t              div_req;
    eflm_pkg::div_rsp_t              div_rsp;
    logic                            q_push;
    logic                            q_full;
    eflm_pkg::res_t                  q_res;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = state_reg == eflm_pkg::ST_IDLE;
    assign cfg_ready     = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= eflm_pkg::BASE_RESET;
            tol_reg  <= eflm_pkg::TOL_RESET;
            rim_reg  <= eflm_pkg::RIM_RESET;
            ncal_reg <= eflm_pkg::NCAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                eflm_pkg::REG_BASE_HEIGHT: base_reg <= cfg_data;
                eflm_pkg::REG_TOLERANCE:   tol_reg  <= cfg_data;
                eflm_pkg::REG_RIM_OFFSET:  rim_reg  <= cfg_data[eflm_pkg::RIM_W-1:0];
                eflm_pkg::REG_CAL_SAMPLES: ncal_reg <= cfg_data[eflm_pkg::NCAL_W-1:0];
                default: ;
            endcase
        end
    end

    // sample datapath
    always_comb
    begin
        echo       = s_axis_tdata[DB-1:0];
        echo_ext   = CW'(echo);
        ld_ext     = CW'(ld_reg);
        tol_ext    = CW'(tol_reg);
        ft_ext     = CW'(ft_reg);
        base_ext   = CW'(base_reg);
        reject     = (echo_ext > ld_ext + tol_ext) || (echo_ext + tol_ext < ld_ext);
        new_ld     = reject ? ld_reg : echo;
        new_ld_ext = CW'(new_ld);
        need_div   = (new_ld != '0) && (ft_ext < base_ext) && (new_ld_ext < base_ext);
        base_diff  = base_ext - new_ld_ext;
        den_diff   = base_ext - ft_ext;
        num_base   = base_diff[KW-1:0];
        cal_cup    = ((echo != '0) && (echo < cup_reg)) ? echo : cup_reg;
        cal_cnt    = cnt_reg + 8'd1;
        cal_need   = (ncal_reg == '0) ? 8'd1 : ncal_reg;
        cal_ft     = FW'(cal_cup) + FW'(rim_reg);
        div_lvl    = (div_rsp.quot > NW'(eflm_pkg::LEVEL_MAX)) ?
                     eflm_pkg::LEVEL_MAX : div_rsp.quot[LW-1:0];
    end

    // result selection
    always_comb
    begin
        prog_first = !emit_idx_reg && flag_prog_reg;
        if (prog_first)
        begin
            q_res.ev = eflm_pkg::EV_PROGRESS;
        end
        else if (flag_reset_reg)
        begin
            q_res.ev = eflm_pkg::EV_RESET;
        end
        else if (flag_pres_reg)
        begin
            q_res.ev = eflm_pkg::EV_PRESENT;
        end
        else
        begin
            q_res.ev = eflm_pkg::EV_FULL;
        end
        q_res.lvl  = prog_first ? lvl_reg : '0;
        q_res.last = !(prog_first && flag_full_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eflm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        cup_next        = cup_reg;
        ft_next         = ft_reg;
        ld_next         = ld_reg;
        disp_next       = disp_reg;
        flag_reset_next = flag_reset_reg;
        flag_pres_next  = flag_pres_reg;
        flag_prog_next  = flag_prog_reg;
        flag_full_next  = flag_full_reg;
        emit_idx_next   = emit_idx_reg;
        lvl_next        = lvl_reg;
        div_req         = '0;
        q_push          = 1'b0;
        unique case (state_reg)
            eflm_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    flag_reset_next = 1'b0;
                    flag_pres_next  = 1'b0;
                    flag_prog_next  = 1'b0;
                    flag_full_next  = 1'b0;
                    emit_idx_next   = 1'b0;
                    state_next      = eflm_pkg::ST_EMIT;
                    if (s_axis_tuser)
                    begin
                        cup_next        = base_ext[DB-1:0];
                        ft_next         = FW'(base_ext[DB-1:0]);
                        disp_next       = '0;
                        phase_next      = eflm_pkg::PH_CAL;
                        cnt_next        = '0;
                        flag_reset_next = 1'b1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            eflm_pkg::PH_RAW:
                            begin
                                ld_next = echo;
                                if (echo_ext <= ft_ext)
                                begin
                                    flag_full_next = 1'b1;
                                    phase_next     = eflm_pkg::PH_CAL;
                                    cnt_next       = '0;
                                end
                                else
                                begin
                                    phase_next = eflm_pkg::PH_FILL;
                                end
                            end
                            eflm_pkg::PH_FILL:
                            begin
                                ld_next = new_ld;
                                if (new_ld_ext <= ft_ext)
                                begin
                                    flag_full_next = 1'b1;
                                    phase_next     = eflm_pkg::PH_CAL;
                                    cnt_next       = '0;
                                end
                                if (need_div)
                                begin
                                    div_req.start = 1'b1;
                                    div_req.num   = (NW'(num_base) << 4) - (NW'(num_base) << 1);
                                    div_req.den   = den_diff[KW-1:0];
                                    state_next    = eflm_pkg::ST_DIV;
                                end
                            end
                            default:
                            begin
                                ld_next  = echo;
                                cup_next = cal_cup;
                                cnt_next = cal_cnt;
                                if (cal_cnt >= cal_need)
                                begin
                                    ft_next        = cal_ft;
                                    flag_pres_next = 1'b1;
                                    phase_next     = eflm_pkg::PH_RAW;
                                    cnt_next       = '0;
                                end
                            end
                        endcase
                    end
                end
            end
            eflm_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_lvl > disp_reg)
                    begin
                        disp_next      = div_lvl;
                        lvl_next       = div_lvl;
                        flag_prog_next = 1'b1;
                    end
                    state_next = eflm_pkg::ST_EMIT;
                end
            end
            eflm_pkg::ST_EMIT:
            begin
                if (!(flag_reset_reg || flag_pres_reg || flag_prog_reg || flag_full_reg))
                begin
                    state_next = eflm_pkg::ST_IDLE;
                end
                else if (!q_full)
                begin
                    q_push = 1'b1;
                    if (q_res.last)
                    begin
                        state_next = eflm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = eflm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= eflm_pkg::PH_CAL;
            cnt_reg        <= '0;
            cup_reg        <= BASE_RST_EXT[DB-1:0];
            ft_reg         <= FW'(BASE_RST_EXT[DB-1:0]);
            ld_reg         <= '0;
            disp_reg       <= '0;
            flag_reset_reg <= 1'b0;
            flag_pres_reg  <= 1'b0;
            flag_prog_reg  <= 1'b0;
            flag_full_reg  <= 1'b0;
            emit_idx_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            cup_reg        <= cup_next;
            ft_reg         <= ft_next;
            ld_reg         <= ld_next;
            disp_reg       <= disp_next;
            flag_reset_reg <= flag_reset_next;
            flag_pres_reg  <= flag_pres_next;
            flag_prog_reg  <= flag_prog_next;
            flag_full_reg  <= flag_full_next;
            emit_idx_reg   <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
    end

    eflm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    eflm_outq u_outq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (q_push),
        .push_res      (q_res),
        .full          (q_full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        disp_reg <= eflm_pkg::LEVEL_MAX)
        else $error("dispensed level above maximum");

    a_reset_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser) |=> (state_reg == eflm_pkg::ST_EMIT && flag_reset_reg
                                      && phase_reg == eflm_pkg::PH_CAL))
        else $error("reset action not followed by reset result");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == eflm_pkg::ST_DIV)
        else $error("division finished outside divide state");

    a_single_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eflm_pkg::ST_EMIT) |-> !(flag_reset_reg && flag_pres_reg))
        else $error("conflicting result flags");

endmodule

// ===== hw/rtl/eflm_div.sv =====
`timescale 1ns / 1ps

module eflm_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  eflm_pkg::div_req_t  req,
    output eflm_pkg::div_rsp_t  rsp
);

    localparam int NW    = eflm_pkg::NUM_W;
    localparam int DW    = eflm_pkg::CFG_W;
    localparam int CNT_W = $clog2(NW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             fits;

    // one restoring step per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NW-1]};
        diff      = rem_sh - {1'b0, den_reg};
        fits      = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], fits};
            rem_next = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !$past(req.start)) |-> (rem_reg < den_reg || den_reg == '0))
        else $error("partial remainder not below divisor");

endmodule

// ===== hw/rtl/eflm_outq.sv =====
`timescale 1ns / 1ps

module eflm_outq
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  eflm_pkg::res_t              push_res,
    output logic                        full,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,  // fill_level
    output logic [1:0]                  m_axis_tuser,  // event_res
    output logic                        m_axis_tlast
);

    eflm_pkg::res_t slot_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           pop;
    eflm_pkg::res_t head;

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign full          = count_reg == 2'd2;
    assign m_axis_tvalid = count_reg != 2'd0;
    assign head          = slot_reg[rd_ptr_reg];
    assign m_axis_tdata  = {{(8 - eflm_pkg::LVL_W){1'b0}}, head.lvl};
    assign m_axis_tuser  = head.ev;
    assign m_axis_tlast  = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_res;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full output queue");

    a_ptr_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule
